@@ rtl/tbp_pkg.sv @@
// Shared types, constants and counter helpers for the tournament branch predictor.
package tbp_pkg;

  localparam int PC_W        = 32;
  localparam int CTR_W       = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;
  localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
  localparam logic [CTR_W-1:0] CTR_THR  = 2'd1;

  typedef enum logic {
    REQ_PREDICT = 1'b0,
    REQ_TRAIN   = 1'b1
  } req_e;

  typedef struct packed {
    req_e            req;
    logic [PC_W-1:0] pc;
    logic            outcome;
  } item_t;

  // back part -> front queue
  typedef struct packed {
    logic pop;
    logic clearing;
  } q_ctl_t;

  function automatic logic ctr_taken(input logic [CTR_W-1:0] c);
    return c > CTR_THR;
  endfunction

  function automatic logic [CTR_W-1:0] ctr_update(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + CTR_W'(1);
    end else begin
      if (c != CTR_MIN) r = c - CTR_W'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/tournament_branch_predictor.sv @@
// Tournament branch predictor top level: request queue front and table back end.
//
// Input channel (in_valid_i / in_stall_o) carries one request word: req_type_i,
// pc_i and outcome_i. A predict request returns one word on the output channel
// (out_valid_o / out_stall_i, payload predict_taken_o); a train request returns
// nothing and updates the choice, global and local counters and both histories.
// Words land in a two-entry queue; the back end then takes each word in turn:
// first it reads the global, choice and local history tables, then it reads the
// local counter at the fetched history, then it evaluates and writes back. The
// dependent local-history -> local-counter lookup sets that order. The back end
// takes the next word only once the last has left evaluation, and a predict word
// waits in evaluation while out_valid_o is held by out_stall_i.
// After reset the block runs a clearing pass over every address of the largest
// table that sets all counters to weakly not-taken and all histories to zero;
// in_stall_o stays high during that pass.
// A held output word stalls the back end on the next predict only; the queue
// keeps accepting words until it is full.
module tournament_branch_predictor #(
  parameter int GLOBAL_HIST_BITS  = 12,
  parameter int LOCAL_INDEX_BITS  = 10,
  parameter int LOCAL_HIST_BITS   = 10,
  parameter int CHOICE_INDEX_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [tbp_pkg::PC_W-1:0] pc_i,
  input  logic                     outcome_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     predict_taken_o
);
  import tbp_pkg::*;

  q_ctl_t ctl;
  logic   head_valid;
  item_t  head;

  tbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .pc_i         (pc_i),
    .outcome_i    (outcome_i),
    .ctl_i        (ctl),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tbp_back #(
    .GLOBAL_HIST_BITS  (GLOBAL_HIST_BITS),
    .LOCAL_INDEX_BITS  (LOCAL_INDEX_BITS),
    .LOCAL_HIST_BITS   (LOCAL_HIST_BITS),
    .CHOICE_INDEX_BITS (CHOICE_INDEX_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .ctl_o           (ctl),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .predict_taken_o (predict_taken_o)
  );

endmodule

@@ rtl/tbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [DEPTH_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [DEPTH_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [2**DEPTH_BITS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tbp_front.sv @@
// Front part: accepts request words, decodes the request type, queues them.
module tbp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [tbp_pkg::PC_W-1:0] pc_i,
  input  logic                  outcome_i,
  input  tbp_pkg::q_ctl_t       ctl_i,
  output logic                  head_valid_o,
  output tbp_pkg::item_t        head_o
);
  import tbp_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  item_t             in_item;

  assign in_stall_o   = (count_q == QCNT_W'(QUEUE_DEPTH)) || ctl_i.clearing;
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    in_item.req     = req_type_i ? REQ_TRAIN : REQ_PREDICT;
    in_item.pc      = pc_i;
    in_item.outcome = outcome_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (ctl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({push, ctl_i.pop})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= in_item;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> count_q != '0)
    else $error("pop from empty queue");

  a_no_push_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clearing |-> !push)
    else $error("word taken during table clear");

endmodule

@@ rtl/tbp_back.sv @@
// Back part: table clear sequencer, table lookups, prediction and training.
module tbp_back #(
  parameter int GLOBAL_HIST_BITS  = 12,
  parameter int LOCAL_INDEX_BITS  = 10,
  parameter int LOCAL_HIST_BITS   = 10,
  parameter int CHOICE_INDEX_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  tbp_pkg::item_t  head_i,
  output tbp_pkg::q_ctl_t ctl_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            predict_taken_o
);
  import tbp_pkg::*;

  localparam int G  = GLOBAL_HIST_BITS;
  localparam int LI = LOCAL_INDEX_BITS;
  localparam int LH = LOCAL_HIST_BITS;
  localparam int C  = CHOICE_INDEX_BITS;
  localparam int M1 = (G > LI) ? G : LI;
  localparam int M2 = (LH > C) ? LH : C;
  localparam int CLR_W = (M1 > M2) ? M1 : M2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_EVAL
  } state_e;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [G-1:0]     ghist_q, ghist_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic             out_taken_q, out_taken_d;

  logic [PC_W-1:0]  hx_rd, hx_wr;
  logic             rd_en, lc_re;
  logic             gc_we, ch_we, lh_we, lc_we;
  logic [G-1:0]     gc_waddr;
  logic [C-1:0]     ch_waddr;
  logic [LI-1:0]    lh_waddr;
  logic [LH-1:0]    lc_waddr;
  logic [CTR_W-1:0] gc_wdata, ch_wdata, lc_wdata;
  logic [LH-1:0]    lh_wdata;
  logic [CTR_W-1:0] gc_rdata, ch_rdata, lc_rdata;
  logic [LH-1:0]    lh_rdata;
  logic             g_guess, l_guess, pick_g, taken, out_free, is_train;

  // history xor pc; upper choice index bits come from pc alone
  assign hx_rd = {{(PC_W - G){1'b0}}, ghist_q} ^ head_i.pc;
  assign hx_wr = {{(PC_W - G){1'b0}}, ghist_q} ^ item_q.pc;

  assign g_guess  = ctr_taken(gc_rdata);
  assign l_guess  = ctr_taken(lc_rdata);
  assign pick_g   = ctr_taken(ch_rdata);
  assign taken    = item_q.outcome;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_train = (item_q.req == REQ_TRAIN);

  assign rd_en = (state_q == ST_IDLE) && head_valid_i;
  assign lc_re = (state_q == ST_HIST);

  assign ctl_o.pop      = rd_en;
  assign ctl_o.clearing = (state_q == ST_CLEAR);

  always_comb begin
    gc_we    = 1'b0;
    ch_we    = 1'b0;
    lh_we    = 1'b0;
    lc_we    = 1'b0;
    gc_waddr = hx_wr[G-1:0];
    ch_waddr = hx_wr[C-1:0];
    lh_waddr = item_q.pc[LI-1:0];
    lc_waddr = lh_rdata;
    gc_wdata = ctr_update(gc_rdata, taken);
    lc_wdata = ctr_update(lc_rdata, taken);
    lh_wdata = {taken, lh_rdata[LH-1:1]};
    if (g_guess != taken && l_guess == taken) begin
      ch_wdata = ctr_update(ch_rdata, 1'b0);
    end else if (g_guess == taken && l_guess != taken) begin
      ch_wdata = ctr_update(ch_rdata, 1'b1);
    end else begin
      ch_wdata = ch_rdata;
    end
    case (state_q)
      ST_CLEAR: begin
        gc_we    = ((clr_q >> G) == '0);
        ch_we    = ((clr_q >> C) == '0);
        lh_we    = ((clr_q >> LI) == '0);
        lc_we    = ((clr_q >> LH) == '0);
        gc_waddr = clr_q[G-1:0];
        ch_waddr = clr_q[C-1:0];
        lh_waddr = clr_q[LI-1:0];
        lc_waddr = clr_q[LH-1:0];
        gc_wdata = CTR_INIT;
        ch_wdata = CTR_INIT;
        lc_wdata = CTR_INIT;
        lh_wdata = '0;
      end
      ST_EVAL: begin
        gc_we = is_train;
        ch_we = is_train;
        lh_we = is_train;
        lc_we = is_train;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    ghist_d     = ghist_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_taken_d = out_taken_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == {CLR_W{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          item_d  = head_i;
          state_d = ST_HIST;
        end
      end
      ST_HIST: state_d = ST_EVAL;
      ST_EVAL: begin
        if (is_train) begin
          ghist_d = {taken, ghist_q[G-1:1]};
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_taken_d = pick_g ? g_guess : l_guess;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ghist_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_taken_q <= 1'b0;
      item_q      <= '0;
    end else begin
      state_q     <= state_d;
      ghist_q     <= ghist_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      out_taken_q <= out_taken_d;
      item_q      <= item_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = out_taken_q;

  tbp_ram #(.WIDTH(CTR_W), .DEPTH_BITS(G)) u_gc_ram (
    .clk_i   (clk_i),
    .we_i    (gc_we),
    .waddr_i (gc_waddr),
    .wdata_i (gc_wdata),
    .re_i    (rd_en),
    .raddr_i (hx_rd[G-1:0]),
    .rdata_o (gc_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH_BITS(C)) u_ch_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (rd_en),
    .raddr_i (hx_rd[C-1:0]),
    .rdata_o (ch_rdata)
  );

  tbp_ram #(.WIDTH(LH), .DEPTH_BITS(LI)) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .re_i    (rd_en),
    .raddr_i (head_i.pc[LI-1:0]),
    .rdata_o (lh_rdata)
  );

  // local counter lookup follows the local history read in the next cycle, at the fetched history
  tbp_ram #(.WIDTH(CTR_W), .DEPTH_BITS(LH)) u_lc_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .re_i    (lc_re),
    .raddr_i (lh_rdata),
    .rdata_o (lc_rdata)
  );

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !ctl_o.pop)
    else $error("queue popped during clear");

  a_hist_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HIST |=> state_q == ST_EVAL)
    else $error("history read not followed by evaluation");

  a_ghist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL && is_train |=>
      ghist_q == {$past(item_q.outcome), $past(ghist_q[G-1:1])})
    else $error("global history not shifted on train");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EVAL && $past(item_q.req) == REQ_PREDICT)
    else $error("result word without predict request");

endmodule

@@ tb/tournament_branch_predictor_tb.sv @@
// Self-checking testbench for the tournament branch predictor: directed and random words.
module tournament_branch_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;

  localparam int GH     = 12;
  localparam int LIB    = 10;
  localparam int LHB    = 10;
  localparam int CIB    = 12;
  localparam int GSIZE  = 1 << GH;
  localparam int LISIZE = 1 << LIB;
  localparam int LCSIZE = 1 << LHB;
  localparam int CSIZE  = 1 << CIB;
  localparam int ITEMS  = 1800;
  localparam int NSITES = 16;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            req_type_i;
  logic [PC_W-1:0] pc_i;
  logic            outcome_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic            predict_taken_o;

  bit calm;
  bit quiet_tail;
  int sent;

  always #4 clk_i = ~clk_i;

  tournament_branch_predictor #(
    .GLOBAL_HIST_BITS (GH),
    .LOCAL_INDEX_BITS (LIB),
    .LOCAL_HIST_BITS  (LHB),
    .CHOICE_INDEX_BITS(CIB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .pc_i           (pc_i),
    .outcome_i      (outcome_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .predict_taken_o(predict_taken_o)
  );

  // Tracks the predictor tables and queues the direction due for each predict word.
  class direction_scoreboard;
    bit [GH-1:0]    ghist;
    bit [CTR_W-1:0] gshare_ctr [GSIZE];
    bit [LHB-1:0]   lhist      [LISIZE];
    bit [CTR_W-1:0] local_ctr  [LCSIZE];
    bit [CTR_W-1:0] choice_ctr [CSIZE];
    bit             pending_taken[$];
    int             errors;

    function new();
      ghist = '0;
      foreach (gshare_ctr[i]) gshare_ctr[i] = CTR_INIT;
      foreach (lhist[i]) lhist[i] = '0;
      foreach (local_ctr[i]) local_ctr[i] = CTR_INIT;
      foreach (choice_ctr[i]) choice_ctr[i] = CTR_INIT;
      errors = 0;
    endfunction

    function bit [CTR_W-1:0] sat_step(bit [CTR_W-1:0] c, bit up);
      if (up) return (c == CTR_MAX) ? c : c + 2'd1;
      return (c == CTR_MIN) ? c : c - 2'd1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_word(req_e req, bit [PC_W-1:0] pc, bit outcome);
      bit [31:0] gi;
      bit [31:0] ci;
      bit [31:0] li;
      bit [31:0] lc;
      bit        g_dir;
      bit        l_dir;
      gi = (32'(ghist) ^ pc) & (GSIZE - 1);
      // upper choice index bits come from pc alone when the table is wider
      ci = (32'(ghist) ^ pc) & (CSIZE - 1);
      li = pc & (LISIZE - 1);
      lc = 32'(lhist[li]);
      g_dir = gshare_ctr[gi] > CTR_THR;
      l_dir = local_ctr[lc] > CTR_THR;
      if (req == REQ_PREDICT) begin
        pending_taken.push_back((choice_ctr[ci] > CTR_THR) ? g_dir : l_dir);
        return;
      end
      // all reads above come before any write of this word
      if (g_dir != outcome && l_dir == outcome) begin
        choice_ctr[ci] = sat_step(choice_ctr[ci], 1'b0);
      end else if (g_dir == outcome && l_dir != outcome) begin
        choice_ctr[ci] = sat_step(choice_ctr[ci], 1'b1);
      end
      gshare_ctr[gi] = sat_step(gshare_ctr[gi], outcome);
      ghist          = {outcome, ghist[GH-1:1]};
      local_ctr[lc]  = sat_step(local_ctr[lc], outcome);
      lhist[li]      = {outcome, lhist[li][LHB-1:1]};
    endfunction

    task check_direction(logic got);
      bit want;
      if (pending_taken.size() == 0) begin
        report("predict_taken word with no predict pending");
        return;
      end
      want = pending_taken.pop_front();
      if (got !== want) report($sformatf("predict_taken %b, want %b", got, want));
    endtask
  endclass

  direction_scoreboard sb = new();

  task idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task send_word(req_e req, logic [PC_W-1:0] pc, logic outcome);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    pc_i       <= pc;
    outcome_i  <= outcome;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(req, pc, outcome);
    sent++;
    if (!calm && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 11));
  endtask

  task drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_taken.size() != 0) @(posedge clk_i);
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_direction(predict_taken_o);
  end

  // receiver stall bursts
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (quiet_tail) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bit [PC_W-1:0] sites [NSITES];
    int            kind  [NSITES];
    int            phase [NSITES];
    int            pick;
    bit            dir;
    bit            mid_pause;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_PREDICT;
    pc_i       <= '0;
    outcome_i  <= 1'b0;
    calm       = 1'b0;
    quiet_tail = 1'b0;
    mid_pause  = 1'b0;
    sent       = 0;
    foreach (sites[i]) begin
      sites[i] = $urandom;
      kind[i]  = $urandom_range(0, 4);
      phase[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fresh tables, extreme pcs, outcome ignored on predict
    send_word(REQ_PREDICT, 32'h0000_0000, 1'b0);
    send_word(REQ_PREDICT, 32'hFFFF_FFFF, 1'b1);
    // saturate upward, fill global history with ones
    repeat (12) send_word(REQ_TRAIN, 32'h0000_0123, 1'b1);
    send_word(REQ_PREDICT, 32'h0000_0123, 1'b0);
    // walk back down through the weak states
    repeat (4) send_word(REQ_TRAIN, 32'h0000_0123, 1'b0);
    send_word(REQ_PREDICT, 32'h0000_0123, 1'b1);
    send_word(REQ_TRAIN, 32'hAAAA_AAAA, 1'b1);
    send_word(REQ_TRAIN, 32'h5555_5555, 1'b0);
    send_word(REQ_PREDICT, 32'hAAAA_AAAA, 1'b0);
    send_word(REQ_PREDICT, 32'h5555_5555, 1'b1);
    drain_results();

    while (sent < ITEMS + 24) begin
      if (sent > ITEMS - 200) begin
        calm       = 1'b1;
        quiet_tail = 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        calm = !calm;
      end
      if (!mid_pause && sent > ITEMS / 2) begin
        drain_results();
        mid_pause = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        // branch site: predict, then resolve with the site's pattern
        pick = $urandom_range(0, NSITES - 1);
        case (kind[pick])
          0: dir = 1'b1;
          1: dir = 1'b0;
          2: dir = phase[pick][0];
          3: dir = (phase[pick] % 3) != 2;
          default: dir = 1'($urandom_range(0, 1));
        endcase
        phase[pick]++;
        send_word(REQ_PREDICT, sites[pick], 1'($urandom_range(0, 1)));
        send_word(REQ_TRAIN, sites[pick], dir);
      end else begin
        send_word($urandom_range(0, 1) ? REQ_TRAIN : REQ_PREDICT, $urandom,
                  1'($urandom_range(0, 1)));
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ tournament_branch_predictor.f @@
rtl/tbp_pkg.sv
rtl/tbp_ram.sv
rtl/tbp_front.sv
rtl/tbp_back.sv
rtl/tournament_branch_predictor.sv
tb/tournament_branch_predictor_tb.sv
